// ----- rtl/velocity_command_shaper_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the velocity command shaper
// Concurrent checks clocked on clk; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef VELOCITY_COMMAND_SHAPER_TOP_MACROS_SVH
`define VELOCITY_COMMAND_SHAPER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// check outside reset
`define VCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// check that also covers the reset cycles
`define VCS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VCS_ASSERT(lbl, prop, msg)
`define VCS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- rtl/vcs_pkg.sv -----
// ----------------------------------------------------------------------------
// vcs_pkg
// Item types, drive mode codes, register indexes and fixed thresholds of the
// velocity command shaper. All values are Q3.12 (1.0 = 4096).
// ----------------------------------------------------------------------------
package vcs_pkg;

  typedef struct packed {
    logic signed [15:0] lin_req;
    logic signed [15:0] ang_req;
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    logic               force_stop;
  } vcs_in_t;

  typedef struct packed {
    logic signed [15:0] linear_cmd;
    logic signed [15:0] angular_cmd;
    logic [2:0]         drive_mode;
  } vcs_out_t;

  typedef enum logic [2:0] {
    MODE_STOP     = 3'd0,
    MODE_STRAIGHT = 3'd1,
    MODE_SHARP    = 3'd2,
    MODE_MEDIUM   = 3'd3,
    MODE_SMALL    = 3'd4
  } drive_mode_t;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINEAR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LINEAR = 1'b1;

  localparam logic [CFG_DAT_W-1:0] MAX_LINEAR_RST = 15'd1229;  // 0.3
  localparam logic [CFG_DAT_W-1:0] MIN_LINEAR_RST = 15'd41;    // 0.01

  // Integer forms of the real thresholds
  localparam logic [16:0]        STRAIGHT_MAG_MAX = 17'd327;   // |x| < 0.08
  localparam logic signed [15:0] GX_STRAIGHT_MIN  = 16'sd820;  // x > 0.2
  localparam logic [16:0]        ANG_SHARP_MIN    = 17'd3277;  // |x| > 0.8
  localparam logic [16:0]        GY_SHARP_MIN     = 17'd1229;  // |y| > 0.3
  localparam logic [16:0]        ANG_MEDIUM_MIN   = 17'd1639;  // |x| > 0.4
  localparam logic [16:0]        GY_MEDIUM_MIN    = 17'd615;   // |y| > 0.15
  localparam logic [16:0]        DAMP_MAG_MAX     = 17'd819;   // |x| < 0.2
  localparam logic signed [15:0] TURN_MIN_CMD     = 16'sd328;  // 0.08
  localparam int                 ONE_SHIFT        = 12;

  // ceil(2^22 / 5): exact floor(n / 5) for n < 2^19
  localparam logic [19:0] RECIP5     = 20'd838861;
  localparam int          RECIP5_SHR = 22;

endpackage

// ----- rtl/velocity_command_shaper_top.sv -----
// ----------------------------------------------------------------------------
// velocity_command_shaper_top
// Classifies each velocity item into a drive mode, scales and limits the
// linear and angular commands, and damps small turns with an angular history.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled and returns one
// result per item; an item passes the s1, s2, s3 and output registers before
// it shows on out_valid. Four register levels carry it: input capture, mode
// decision with scaled numerators, constant division with saturation and
// clamp, and the history stage whose running sum (add new entry, drop oldest)
// sets the one-item-per-cycle figure. Stalls back up stage by stage, so a full
// pipeline still takes an item in any cycle the output moves. The angular
// history is a shift line of HISTORY_DEPTH entries and needs no clearing after
// reset. max_linear and min_linear are to be written through the cfg port only
// while the block holds no item; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "velocity_command_shaper_top_macros.svh"

module velocity_command_shaper_top #(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  vcs_pkg::vcs_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output vcs_pkg::vcs_out_t                out_data,
  input  logic                             cfg_wr_en,
  input  logic [vcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vcs_pkg::CFG_DAT_W-1:0]    cfg_wdata
);

  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W  = 16 + $clog2(HISTORY_DEPTH);
  localparam int CMP_W  = SUM_W + 4;
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HISTORY_DEPTH);
  localparam logic [FILL_W-1:0] FILL_DAMP = FILL_W'(3);

  typedef enum logic [1:0] {
    DIV_2  = 2'b00,
    DIV_5  = 2'b01,
    DIV_10 = 2'b10
  } div_sel_t;

  function automatic logic [16:0] mag17(input logic signed [15:0] v);
    logic [16:0] ext;
    ext = {v[15], v};
    return v[15] ? 17'(-ext) : ext;
  endfunction

  function automatic logic [16:0] div5(input logic [18:0] n);
    logic [38:0] prod;
    prod = {20'd0, n} * {19'd0, vcs_pkg::RECIP5};
    return prod[vcs_pkg::RECIP5_SHR +: 17];
  endfunction

  function automatic logic [16:0] div_by(input logic [18:0] n, input div_sel_t d);
    logic [16:0] q;
    case (d)
      DIV_5:   q = div5(n);
      DIV_10:  q = div5({1'b0, n[18:1]});
      default: q = n[17:1];
    endcase
    return q;
  endfunction

  // ---------------- configuration ----------------
  logic [vcs_pkg::CFG_DAT_W-1:0] max_linear_r;
  logic [vcs_pkg::CFG_DAT_W-1:0] min_linear_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_linear_r <= vcs_pkg::MAX_LINEAR_RST;
      min_linear_r <= vcs_pkg::MIN_LINEAR_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        vcs_pkg::CFG_MAX_LINEAR: max_linear_r <= cfg_wdata;
        vcs_pkg::CFG_MIN_LINEAR: min_linear_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic adv_out, mv1, mv2, mv3, in_accept;

  assign adv_out   = !out_valid_r || !out_stall;
  assign mv3       = v3_r && adv_out;
  assign mv2       = v2_r && (!v3_r || mv3);
  assign mv1       = v1_r && (!v2_r || mv2);
  assign in_stall  = v1_r && !mv1;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= in_accept || (v1_r && !mv1);
      v2_r        <= mv1 || (v2_r && !mv2);
      v3_r        <= mv2 || (v3_r && !mv3);
      out_valid_r <= mv3 || (out_valid_r && out_stall);
    end
  end

  // ---------------- stage 1: capture ----------------
  vcs_pkg::vcs_in_t s1_r;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= in_data;
    end
  end

  // classify and build the rounding numerators |v| * p + q / 2
  logic [16:0] ang_mag1, gy_mag1, lin_mag1;
  logic [18:0] ang_ext1, lin_ext1;
  logic        behind1, large1, med_off1, straight1, sharp1, medium1;
  logic [18:0] ang_num1, lin_num1;
  div_sel_t    ang_div1, lin_div1;
  vcs_pkg::drive_mode_t mode1;

  assign ang_mag1 = mag17(s1_r.ang_req);
  assign gy_mag1  = mag17(s1_r.goal_y);
  assign lin_mag1 = mag17(s1_r.lin_req);
  assign ang_ext1 = {2'b00, ang_mag1};
  assign lin_ext1 = {2'b00, lin_mag1};

  assign behind1   = s1_r.goal_x[15];
  assign large1    = gy_mag1 >= vcs_pkg::GY_SHARP_MIN;
  assign med_off1  = gy_mag1 >= vcs_pkg::GY_MEDIUM_MIN;
  assign straight1 = (ang_mag1 <= vcs_pkg::STRAIGHT_MAG_MAX) &&
                     (gy_mag1 <= vcs_pkg::STRAIGHT_MAG_MAX) &&
                     (s1_r.goal_x >= vcs_pkg::GX_STRAIGHT_MIN);
  assign sharp1    = (ang_mag1 >= vcs_pkg::ANG_SHARP_MIN) || large1 || behind1;
  assign medium1   = (ang_mag1 >= vcs_pkg::ANG_MEDIUM_MIN) || med_off1;

  always_comb begin
    mode1    = vcs_pkg::MODE_SMALL;
    ang_num1 = '0;
    ang_div1 = DIV_2;
    lin_num1 = '0;
    lin_div1 = DIV_2;
    if (s1_r.force_stop) begin
      mode1 = vcs_pkg::MODE_STOP;
    end else if (straight1) begin
      // angular goes to zero, linear passes: (2|v| + 1) / 2
      mode1    = vcs_pkg::MODE_STRAIGHT;
      lin_num1 = {lin_ext1[17:0], 1'b1};
    end else if (sharp1) begin
      mode1 = vcs_pkg::MODE_SHARP;
      if (behind1) begin
        ang_num1 = ang_ext1 * 19'd9 + 19'd2;
        ang_div1 = DIV_5;
        lin_num1 = lin_ext1 * 19'd3 + 19'd5;
        lin_div1 = DIV_10;
      end else if (large1) begin
        ang_num1 = ang_ext1 * 19'd3 + 19'd1;
        ang_div1 = DIV_2;
        lin_num1 = lin_ext1 * 19'd2 + 19'd2;
        lin_div1 = DIV_5;
      end else begin
        ang_num1 = ang_ext1 * 19'd13 + 19'd5;
        ang_div1 = DIV_10;
        lin_num1 = lin_ext1 + 19'd1;
        lin_div1 = DIV_2;
      end
    end else if (medium1) begin
      mode1    = vcs_pkg::MODE_MEDIUM;
      ang_num1 = ang_ext1 * 19'd6 + 19'd2;
      ang_div1 = DIV_5;
      lin_num1 = lin_ext1 * 19'd7 + 19'd5;
      lin_div1 = DIV_10;
    end else begin
      ang_num1 = ang_ext1 * 19'd11 + 19'd5;
      ang_div1 = DIV_10;
      lin_num1 = {lin_ext1[17:0], 1'b1};
    end
  end

  // ---------------- stage 2: divide, saturate, clamp ----------------
  logic [18:0]          s2_ang_num_r, s2_lin_num_r;
  div_sel_t             s2_ang_div_r, s2_lin_div_r;
  logic                 s2_ang_neg_r, s2_lin_neg_r;
  vcs_pkg::drive_mode_t s2_mode_r;

  always_ff @(posedge clk) begin
    if (mv1) begin
      s2_ang_num_r <= ang_num1;
      s2_ang_div_r <= ang_div1;
      s2_ang_neg_r <= s1_r.ang_req[15];
      s2_lin_num_r <= lin_num1;
      s2_lin_div_r <= lin_div1;
      s2_lin_neg_r <= s1_r.lin_req[15];
      s2_mode_r    <= mode1;
    end
  end

  logic [16:0]        ang_q2, lin_q2;
  logic signed [17:0] ang_s2, lin_s2, lim2;
  logic signed [15:0] ang_sat2, lin_clamp2;

  assign ang_q2 = div_by(s2_ang_num_r, s2_ang_div_r);
  assign lin_q2 = div_by(s2_lin_num_r, s2_lin_div_r);
  assign ang_s2 = s2_ang_neg_r ? -$signed({1'b0, ang_q2}) : $signed({1'b0, ang_q2});
  assign lin_s2 = s2_lin_neg_r ? -$signed({1'b0, lin_q2}) : $signed({1'b0, lin_q2});
  assign lim2   = $signed({3'b000, max_linear_r});

  always_comb begin
    if (ang_s2 > 18'sd32767) begin
      ang_sat2 = 16'sh7FFF;
    end else if (ang_s2 < -18'sd32768) begin
      ang_sat2 = 16'sh8000;
    end else begin
      ang_sat2 = ang_s2[15:0];
    end
    if (lin_s2 > lim2) begin
      lin_clamp2 = lim2[15:0];
    end else if (lin_s2 < -lim2) begin
      lin_clamp2 = 16'(-lim2);
    end else begin
      lin_clamp2 = lin_s2[15:0];
    end
  end

  // ---------------- stage 3: history, damping, minimums ----------------
  logic signed [15:0]   s3_ang_r, s3_lin_r;
  vcs_pkg::drive_mode_t s3_mode_r;

  always_ff @(posedge clk) begin
    if (mv2) begin
      s3_ang_r  <= ang_sat2;
      s3_lin_r  <= lin_clamp2;
      s3_mode_r <= s2_mode_r;
    end
  end

  logic signed [15:0]      hist_r [HISTORY_DEPTH];
  logic [FILL_W-1:0]       fill_r, fill_upd;
  logic signed [SUM_W-1:0] sum_r, sum_upd, sum_drop;
  logic [SUM_W-1:0]        sum_mag;
  logic [CMP_W-1:0]        sum_x10, fill_x1;
  logic                    ring_full, ring_wr;

  assign ring_full = fill_r == FILL_FULL;
  assign ring_wr   = mv3 && (s3_mode_r != vcs_pkg::MODE_STOP);
  // drop the oldest entry once the history is full
  assign sum_drop  = ring_full ? SUM_W'(hist_r[HISTORY_DEPTH-1]) : '0;
  assign sum_upd   = sum_r + SUM_W'(s3_ang_r) - sum_drop;
  assign fill_upd  = ring_full ? fill_r : fill_r + FILL_W'(1);
  assign sum_mag   = sum_upd[SUM_W-1] ? SUM_W'(-sum_upd) : SUM_W'(sum_upd);
  assign sum_x10   = (CMP_W'(sum_mag) << 3) + (CMP_W'(sum_mag) << 1);
  assign fill_x1   = CMP_W'(fill_upd) << vcs_pkg::ONE_SHIFT;

  always_ff @(posedge clk) begin
    if (ring_wr) begin
      hist_r[0] <= s3_ang_r;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      sum_r  <= '0;
    end else if (ring_wr) begin
      fill_r <= fill_upd;
      sum_r  <= sum_upd;
    end
  end

  logic [16:0]        ang_mag3, lin_mag3, damp_q3;
  logic [18:0]        damp_num3;
  logic               damp3, turn_min3, lin_min3;
  logic signed [15:0] ang_fin3, lin_fin3, min_cmd3;

  assign ang_mag3  = mag17(s3_ang_r);
  assign lin_mag3  = mag17(s3_lin_r);
  assign damp_num3 = {1'b0, ang_mag3, 1'b0} + {2'b00, ang_mag3} + 19'd5;
  assign damp_q3   = div5({1'b0, damp_num3[18:1]});
  assign min_cmd3  = $signed({1'b0, min_linear_r});

  assign damp3 = ((s3_mode_r == vcs_pkg::MODE_STRAIGHT) ||
                  (s3_mode_r == vcs_pkg::MODE_SMALL)) &&
                 (fill_upd >= FILL_DAMP) && (sum_x10 < fill_x1) &&
                 (ang_mag3 <= vcs_pkg::DAMP_MAG_MAX);
  assign turn_min3 = ((s3_mode_r == vcs_pkg::MODE_SHARP) ||
                      (s3_mode_r == vcs_pkg::MODE_MEDIUM)) &&
                     (s3_ang_r != 16'sd0) && (ang_mag3 <= vcs_pkg::STRAIGHT_MAG_MAX);
  assign lin_min3  = (s3_lin_r != 16'sd0) && (lin_mag3 < {2'b00, min_linear_r});

  always_comb begin
    ang_fin3 = s3_ang_r;
    lin_fin3 = s3_lin_r;
    if (s3_mode_r == vcs_pkg::MODE_STOP) begin
      ang_fin3 = '0;
      lin_fin3 = '0;
    end else begin
      if (damp3) begin
        ang_fin3 = s3_ang_r[15] ? -$signed({1'b0, damp_q3[14:0]})
                                :  $signed({1'b0, damp_q3[14:0]});
      end else if (turn_min3) begin
        ang_fin3 = s3_ang_r[15] ? -vcs_pkg::TURN_MIN_CMD : vcs_pkg::TURN_MIN_CMD;
      end
      if (lin_min3) begin
        lin_fin3 = s3_lin_r[15] ? -min_cmd3 : min_cmd3;
      end
    end
  end

  // ---------------- output register ----------------
  vcs_pkg::vcs_out_t out_r;

  always_ff @(posedge clk) begin
    if (mv3) begin
      out_r.linear_cmd  <= lin_fin3;
      out_r.angular_cmd <= ang_fin3;
      out_r.drive_mode  <= 3'(s3_mode_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------- assertions ----------------
  logic out_stop, out_straight, out_cmd_zero;

  assign out_stop     = out_valid_r && (out_r.drive_mode == 3'(vcs_pkg::MODE_STOP));
  assign out_straight = out_valid_r && (out_r.drive_mode == 3'(vcs_pkg::MODE_STRAIGHT));
  assign out_cmd_zero = (out_r.linear_cmd == 16'sd0) && (out_r.angular_cmd == 16'sd0);

  `VCS_ASSERT(a_fill_bound, fill_r <= FILL_FULL, "history fill above depth")
  `VCS_ASSERT(a_fill_hold, !ring_wr |=> $stable(fill_r) && $stable(sum_r), "history moved idle")
  `VCS_ASSERT(a_stop_zero, out_stop |-> out_cmd_zero, "stop item not zero")
  `VCS_ASSERT(a_straight_ang, out_straight |-> out_r.angular_cmd == 16'sd0, "straight item turns")
  `VCS_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid_r && !v1_r && fill_r == '0, "not reset")

endmodule
